// ===== rtl/usb_can_record_stream_decoder_assert.svh =====
// Assertion macros used by the top RTL file of the record stream decoder.
`ifndef USB_CAN_RECORD_STREAM_DECODER_ASSERT_SVH
`define USB_CAN_RECORD_STREAM_DECODER_ASSERT_SVH

// Implication checked at every clock edge, reset excluded.
`define UCRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after its antecedent.
`define UCRD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ucrd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucrd_pkg
// Types and constants of the USB CAN record stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package ucrd_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_COUNT  = 4'd1,
    PH_STATUS = 4'd2,
    PH_ID     = 4'd3,
    PH_DSTAMP = 4'd4,
    PH_DATA   = 4'd5,
    PH_FUNC   = 4'd6,
    PH_NUM    = 4'd7,
    PH_SSTAMP = 4'd8,
    PH_SKIP   = 4'd9,
    PH_DONE   = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    BS_ACTIVE  = 2'd0,
    BS_WARNING = 2'd1,
    BS_PASSIVE = 2'd2,
    BS_OFF     = 2'd3
  } bus_state_t;

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_STATE     = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW  = 2'd2;
  localparam logic [1:0] KIND_MALFORMED = 2'd3;

  localparam logic       CMD_BYTE    = 1'b0;
  localparam logic       CMD_RESTART = 1'b1;

  localparam int SL_STAMP_BIT  = 7;
  localparam int SL_STATUS_BIT = 6;
  localparam int SL_EXT_BIT    = 5;
  localparam int SL_RTR_BIT    = 4;

  localparam logic [7:0] FN_ERROR   = 8'd1;
  localparam logic [7:0] FN_ANALOG  = 8'd2;
  localparam logic [7:0] FN_BUSLOAD = 8'd3;
  localparam logic [7:0] FN_STAMP   = 8'd4;

  localparam logic [7:0] ERR_WARN     = 8'h04;
  localparam logic [7:0] ERR_PASSIVE  = 8'h08;
  localparam logic [7:0] ERR_BUSOFF   = 8'h10;
  localparam logic [7:0] ERR_OVF_ONLY = 8'h40;
  localparam logic [7:0] ERR_OVF_MASK = 8'h42;

  // one input transaction
  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [28:0] frame_id;
    logic        extended;
    logic        remote;
    logic [3:0]  length_code;
    logic [63:0] payload;
    logic [15:0] stamp;
    logic        stamp_valid;
    logic [1:0]  bus_condition;
  } out_item_t;

  // error machine outcome
  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    bus_state_t bus_nxt;
  } err_res_t;

endpackage
`default_nettype wire

// ===== rtl/ucrd_stream_if.sv =====
// ----------------------------------------------------------------------------
// ucrd_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface ucrd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ucrd_err_fsm.sv =====
// ----------------------------------------------------------------------------
// ucrd_err_fsm
// Bus error state decision for one status record of the error function.
// ----------------------------------------------------------------------------
`default_nettype none
module ucrd_err_fsm (
  input  wire logic [7:0]          num,
  input  wire logic                ref_seen,
  input  wire ucrd_pkg::bus_state_t cur,
  output ucrd_pkg::err_res_t       res
);
  ucrd_pkg::bus_state_t nxt;
  logic ovf;
  logic to_active;
  logic ignore;

  // next bus state
  always_comb begin
    nxt = cur;
    ovf = 1'b0;
    to_active = 1'b0;
    ignore = (num == ucrd_pkg::ERR_OVF_ONLY) && !ref_seen;
    unique case (cur)
      ucrd_pkg::BS_ACTIVE, ucrd_pkg::BS_WARNING: begin
        if (cur == ucrd_pkg::BS_ACTIVE && (num & ucrd_pkg::ERR_WARN) != 8'd0)
          nxt = ucrd_pkg::BS_WARNING;
        else if ((num & ucrd_pkg::ERR_PASSIVE) != 8'd0) nxt = ucrd_pkg::BS_PASSIVE;
        else if ((num & ucrd_pkg::ERR_BUSOFF) != 8'd0) nxt = ucrd_pkg::BS_OFF;
        else if ((num & ucrd_pkg::ERR_OVF_MASK) != 8'd0) ovf = 1'b1;
        else if ((num & ucrd_pkg::ERR_WARN) == 8'd0) to_active = 1'b1;
      end
      ucrd_pkg::BS_PASSIVE: begin
        if ((num & ucrd_pkg::ERR_BUSOFF) != 8'd0) nxt = ucrd_pkg::BS_OFF;
        else if ((num & ucrd_pkg::ERR_WARN) != 8'd0) nxt = ucrd_pkg::BS_WARNING;
        else if ((num & ucrd_pkg::ERR_OVF_MASK) != 8'd0) ovf = 1'b1;
        else if ((num & ucrd_pkg::ERR_PASSIVE) == 8'd0) to_active = 1'b1;
      end
      default: ;
    endcase
  end

  // outcome
  always_comb begin
    res.emit = 1'b0;
    res.kind = ucrd_pkg::KIND_STATE;
    res.bus_nxt = cur;
    if (!ignore) begin
      if (to_active) begin
        res.bus_nxt = ucrd_pkg::BS_ACTIVE;
      end else if (ovf) begin
        res.emit = 1'b1;
        res.kind = ucrd_pkg::KIND_OVERFLOW;
      end else if (nxt != cur) begin
        res.emit = 1'b1;
        res.bus_nxt = nxt;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/usb_can_record_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// usb_can_record_stream_decoder
// Byte-serial parser of adapter packets into CAN frame and error results.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in      | in  | cmd, in_byte, first_byte, last_byte
//  out     | out | result_kind .. bus_condition
//
//  One byte per cycle while input is not stalled; the parse state updates in the cycle the byte is taken.
//  A result sits in the output register in the cycle after the byte that completes it.
//  A new byte is taken while a result waits as long as the register is free
//  or being emptied in that cycle; otherwise input stalls.
//  Reset (rst_n low, synchronous) returns to the idle phase and bus active.
`default_nettype none
`include "usb_can_record_stream_decoder_assert.svh"
module usb_can_record_stream_decoder #(
  parameter int MAX_DATA_BYTES = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  ucrd_stream_if.sink   in_ch,
  ucrd_stream_if.source out_ch
);
  localparam int CW = $clog2(MAX_DATA_BYTES);

  ucrd_pkg::phase_t     phase_r, phase_nxt;
  ucrd_pkg::bus_state_t bus_r, bus_nxt;
  logic [3:0]  fbc_r, fbc_nxt, skip_r, skip_nxt;
  logic [7:0]  tot_r, tot_nxt, ridx_r, ridx_nxt, didx_r, didx_nxt;
  logic [7:0]  sl_r, sl_nxt, fn_r, fn_nxt, num_r, num_nxt, prev_r, prev_nxt;
  logic [15:0] st_r, st_nxt;
  logic [31:0] id_r, id_nxt;
  logic [63:0] pay_r, pay_nxt;
  logic        ref_r, ref_nxt;
  logic        ov_r;
  ucrd_pkg::out_item_t res_r, res_c;
  logic        have_c;

  ucrd_pkg::in_item_t it;
  logic acc, b_first;
  logic [7:0] b;
  logic [7:0] err_num;
  ucrd_pkg::err_res_t er;
  logic [3:0] slen;

  assign it  = in_ch.data;
  assign b   = it.in_byte;
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !ov_r || out_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;
  assign slen = sl_r[3:0];

  // error number byte: the current byte when the body runs on the number byte
  assign err_num = (phase_r == ucrd_pkg::PH_NUM) ? b : num_r;

  ucrd_err_fsm u_err (.num(err_num), .ref_seen(ref_r), .cur(bus_r), .res(er));

  // parse step
  always_comb begin
    logic [15:0] stmp;
    logic        sdone, short_pkt, do_body, do_fin, do_next;
    logic [3:0]  skip_v, clen;
    logic [7:0]  ridx_inc;
    stmp = st_r; sdone = 1'b0; short_pkt = 1'b0; do_body = 1'b0;
    do_fin = 1'b0; do_next = 1'b0; skip_v = slen; clen = 4'd0; ridx_inc = 8'd0;
    phase_nxt = phase_r; bus_nxt = bus_r; fbc_nxt = fbc_r; skip_nxt = skip_r;
    tot_nxt = tot_r; ridx_nxt = ridx_r; didx_nxt = didx_r; sl_nxt = sl_r;
    fn_nxt = fn_r; num_nxt = num_r; prev_nxt = prev_r; st_nxt = st_r;
    id_nxt = id_r; pay_nxt = pay_r; ref_nxt = ref_r;
    have_c = 1'b0; res_c = '0;
    b_first = 1'b0;
    if (it.cmd == ucrd_pkg::CMD_RESTART) begin
      bus_nxt = ucrd_pkg::BS_ACTIVE;
    end else begin
      if (it.first_byte) begin
        phase_nxt = ucrd_pkg::PH_COUNT; fbc_nxt = '0; skip_nxt = '0;
        tot_nxt = '0; ridx_nxt = '0; didx_nxt = '0; st_nxt = '0; prev_nxt = '0;
        id_nxt = '0; pay_nxt = '0; short_pkt = 1'b1;
      end else begin
        case (phase_r)
          ucrd_pkg::PH_COUNT: begin
            tot_nxt = b; ridx_nxt = '0; didx_nxt = '0;
            phase_nxt = (b != 8'd0) ? ucrd_pkg::PH_STATUS : ucrd_pkg::PH_DONE;
            short_pkt = 1'b1;
          end
          ucrd_pkg::PH_STATUS: begin
            sl_nxt = b; fbc_nxt = '0; id_nxt = '0;
            phase_nxt = b[ucrd_pkg::SL_STATUS_BIT] ? ucrd_pkg::PH_FUNC : ucrd_pkg::PH_ID;
          end
          ucrd_pkg::PH_ID: begin
            id_nxt = id_r | ({24'd0, b} << {fbc_r[1:0], 3'd0});
            fbc_nxt = fbc_r + 4'd1;
            if (fbc_nxt >= (sl_r[ucrd_pkg::SL_EXT_BIT] ? 4'd4 : 4'd2)) begin
              fbc_nxt = '0; pay_nxt = '0; phase_nxt = ucrd_pkg::PH_DSTAMP;
            end
          end
          ucrd_pkg::PH_FUNC: begin
            fn_nxt = b; phase_nxt = ucrd_pkg::PH_NUM;
          end
          ucrd_pkg::PH_NUM: begin
            num_nxt = b; fbc_nxt = '0;
            if (sl_r[ucrd_pkg::SL_STAMP_BIT]) phase_nxt = ucrd_pkg::PH_SSTAMP;
            else do_body = 1'b1;
          end
          ucrd_pkg::PH_DSTAMP, ucrd_pkg::PH_SSTAMP: begin
            b_first = (phase_r == ucrd_pkg::PH_DSTAMP) ? (didx_r == 8'd0)
                                                      : (ridx_r == 8'd0);
            if (b_first) begin
              if (fbc_r == 4'd0) begin
                pay_nxt = {56'd0, b}; fbc_nxt = 4'd1;
              end else begin
                stmp = {b, pay_r[7:0]}; st_nxt = stmp; prev_nxt = pay_r[7:0];
                fbc_nxt = '0; sdone = 1'b1;
              end
            end else begin
              stmp = (b < prev_r) ? st_r + 16'h0100 : st_r;
              stmp = {stmp[15:8], b}; st_nxt = stmp; prev_nxt = b; sdone = 1'b1;
            end
            if (sdone) begin
              if (phase_r == ucrd_pkg::PH_SSTAMP) begin
                do_body = 1'b1;
              end else begin
                pay_nxt = '0; fbc_nxt = '0;
                if (sl_r[ucrd_pkg::SL_RTR_BIT] || slen == 4'd0) do_fin = 1'b1;
                else phase_nxt = ucrd_pkg::PH_DATA;
              end
            end
          end
          ucrd_pkg::PH_DATA: begin
            if (fbc_r < 4'(MAX_DATA_BYTES))
              pay_nxt = pay_r | ({56'd0, b} << {fbc_r[CW-1:0], 3'd0});
            fbc_nxt = fbc_r + 4'd1;
            if (fbc_nxt == slen) do_fin = 1'b1;
          end
          ucrd_pkg::PH_SKIP: begin
            if (fn_r == ucrd_pkg::FN_STAMP && skip_r >= 4'd2) begin
              if (fbc_r == 4'd0) pay_nxt = {56'd0, b};
              else if (fbc_r == 4'd1) st_nxt = {b, pay_r[7:0]};
            end
            fbc_nxt = fbc_r + 4'd1;
            if (fbc_nxt == skip_r) do_next = 1'b1;
          end
          default: ;
        endcase
        // status record body
        if (do_body) begin
          case (fn_r)
            ucrd_pkg::FN_ERROR: begin
              bus_nxt = er.bus_nxt;
              if (er.emit) begin
                have_c = 1'b1;
                res_c.result_kind = er.kind;
                res_c.stamp_valid = sl_r[ucrd_pkg::SL_STAMP_BIT];
                res_c.stamp = sl_r[ucrd_pkg::SL_STAMP_BIT] ? stmp : 16'd0;
              end
            end
            ucrd_pkg::FN_ANALOG:  skip_v = 4'd2;
            ucrd_pkg::FN_BUSLOAD: skip_v = 4'd1;
            ucrd_pkg::FN_STAMP:   ref_nxt = 1'b1;
            default: ;
          endcase
          skip_nxt = skip_v; fbc_nxt = '0; pay_nxt = '0;
          if (skip_v == 4'd0) do_next = 1'b1;
          else phase_nxt = ucrd_pkg::PH_SKIP;
        end
        // data frame completion
        if (do_fin) begin
          clen = (slen > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : slen;
          have_c = 1'b1;
          res_c.result_kind = ucrd_pkg::KIND_DATA;
          res_c.extended = sl_r[ucrd_pkg::SL_EXT_BIT];
          res_c.remote = sl_r[ucrd_pkg::SL_RTR_BIT];
          res_c.frame_id = sl_r[ucrd_pkg::SL_EXT_BIT] ? id_nxt[31:3]
                                                      : {18'd0, id_nxt[15:5]};
          res_c.length_code = clen;
          res_c.payload = sl_r[ucrd_pkg::SL_RTR_BIT] ? 64'd0 : pay_nxt;
          res_c.stamp = stmp;
          res_c.stamp_valid = 1'b1;
          didx_nxt = didx_r + 8'd1;
          do_next = 1'b1;
        end
        if (do_next) begin
          ridx_inc = ridx_r + 8'd1;
          ridx_nxt = ridx_inc;
          phase_nxt = (ridx_inc == tot_r) ? ucrd_pkg::PH_DONE : ucrd_pkg::PH_STATUS;
        end
      end
      // end of packet
      if (it.last_byte) begin
        if (!have_c && phase_nxt != ucrd_pkg::PH_IDLE &&
            (short_pkt || phase_nxt != ucrd_pkg::PH_DONE)) begin
          have_c = 1'b1;
          res_c = '0;
          res_c.result_kind = ucrd_pkg::KIND_MALFORMED;
        end
        phase_nxt = ucrd_pkg::PH_IDLE;
      end
    end
    res_c.bus_condition = bus_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ucrd_pkg::PH_IDLE; bus_r <= ucrd_pkg::BS_ACTIVE;
      fbc_r <= '0; skip_r <= '0; tot_r <= '0; ridx_r <= '0; didx_r <= '0;
      sl_r <= '0; fn_r <= '0; num_r <= '0; prev_r <= '0; st_r <= '0;
      id_r <= '0; pay_r <= '0; ref_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt; bus_r <= bus_nxt; fbc_r <= fbc_nxt; skip_r <= skip_nxt;
      tot_r <= tot_nxt; ridx_r <= ridx_nxt; didx_r <= didx_nxt; sl_r <= sl_nxt;
      fn_r <= fn_nxt; num_r <= num_nxt; prev_r <= prev_nxt; st_r <= st_nxt;
      id_r <= id_nxt; pay_r <= pay_nxt; ref_r <= ref_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (acc && have_c) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && have_c) res_r <= res_c;
  end

  `UCRD_ASSERT_IMP(a_stall_hold, ov_r && !out_ch.ready, !in_ch.ready, "input taken over full result")
  `UCRD_ASSERT_NXT(a_res_loaded, acc && have_c, ov_r, "result lost")
  `UCRD_ASSERT_NXT(a_restart, acc && it.cmd == ucrd_pkg::CMD_RESTART, bus_r == ucrd_pkg::BS_ACTIVE, "restart ignored")
  `UCRD_ASSERT_NXT(a_last_idle, acc && it.cmd == ucrd_pkg::CMD_BYTE && it.last_byte, phase_r == ucrd_pkg::PH_IDLE, "packet not closed")
endmodule
`default_nettype wire
